@@ rtl/huffman_tree_walk_decoder_macros.svh @@
// Assertion macros used by the tree-walk decoder walk sequencer.
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HTWD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HTWD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/htwd_pkg.sv @@
// Shared types and constants of the tree-walk decoder.
package htwd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CNT_W          = 32;
  localparam int BYTE_W         = 8;
  localparam int BIT_IDX_W      = $clog2(BYTE_W);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    node_t            node;
  } node_wr_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             done;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_FLUSH
  } state_t;

  // Where the entry examined in a step comes from and what it is.
  typedef enum logic [1:0] {
    MODE_ROOT,
    MODE_CUR,
    MODE_CHILD
  } mode_t;

endpackage

@@ rtl/htwd_node_mem.sv @@
// Node table: one write port, one registered read port.
module htwd_node_mem #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                        clk,
  input  htwd_pkg::node_wr_t          wr,
  input  logic [htwd_pkg::IDX_W-1:0]  rd_addr,
  output htwd_pkg::node_t             rd_node
);

  localparam int ADDR_W = $clog2(NODE_COUNT);

  htwd_pkg::node_t mem [NODE_COUNT];
  htwd_pkg::node_t rd_data;
  logic            rd_oor;
  logic            wr_in_range;
  logic            rd_in_range;

  assign wr_in_range = {1'b0, wr.addr} < (htwd_pkg::IDX_W + 1)'(NODE_COUNT);
  assign rd_in_range = {1'b0, rd_addr} < (htwd_pkg::IDX_W + 1)'(NODE_COUNT);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.node;
    end
    rd_data <= mem[rd_addr[ADDR_W-1:0]];
    rd_oor  <= !rd_in_range;
  end

  // Indexes past the table read as an internal node with both children at the root.
  assign rd_node = rd_oor ? '0 : rd_data;

endmodule

@@ rtl/htwd_walk_seq.sv @@
// Walk sequencer: one tree step per cycle over the bits of a coded byte, unless a stall holds the step.
`include "huffman_tree_walk_decoder_macros.svh"

module htwd_walk_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [htwd_pkg::IDX_W-1:0]    node_index,
  input  logic [htwd_pkg::IDX_W-1:0]    left_child,
  input  logic [htwd_pkg::IDX_W-1:0]    right_child,
  input  logic                          leaf_flag,
  input  logic [htwd_pkg::SYM_W-1:0]    leaf_symbol,
  input  logic [htwd_pkg::BYTE_W-1:0]   coded_byte,
  input  logic [htwd_pkg::CNT_W-1:0]    symbol_limit,
  output htwd_pkg::node_wr_t            node_wr,
  output logic [htwd_pkg::IDX_W-1:0]    rd_addr,
  input  htwd_pkg::node_t               rd_node,
  output logic                          res_push,
  output htwd_pkg::result_t             res,
  input  logic                          res_room
);

  htwd_pkg::state_t                   state_q, state_next;
  htwd_pkg::mode_t                    mode_q, mode_next;
  logic [htwd_pkg::BIT_IDX_W-1:0]     bit_idx_q, bit_idx_next;
  logic [htwd_pkg::BYTE_W-1:0]        byte_q, byte_next;
  logic [htwd_pkg::IDX_W-1:0]         walk_q, walk_next;
  logic [htwd_pkg::CNT_W-1:0]         count_q, count_next;
  logic [htwd_pkg::IDX_W-1:0]         rd_addr_q;
  htwd_pkg::node_t                    root_q, root_next;
  logic                               pend_valid_q, pend_valid_next;
  htwd_pkg::result_t                  pend_q, pend_next;

  htwd_pkg::node_t                    cur_node;
  logic                               in_fire;
  logic                               limit_hit;
  logic                               last_bit;
  logic                               cur_bit;
  logic                               next_bit;
  logic [htwd_pkg::CNT_W-1:0]         count_inc;
  logic                               stop;
  logic                               emit;
  logic                               advance;
  logic                               go_child;
  logic                               set_walk;
  logic [htwd_pkg::IDX_W-1:0]         child_addr;
  logic                               stall;

  assign in_fire   = in_valid && in_ready;
  assign cur_node  = (mode_q == htwd_pkg::MODE_ROOT) ? root_q : rd_node;
  assign limit_hit = count_q >= symbol_limit;
  assign last_bit  = bit_idx_q == '0;
  assign cur_bit   = byte_q[bit_idx_q];
  assign next_bit  = byte_q[htwd_pkg::BIT_IDX_W'(bit_idx_q - 1'b1)];
  assign count_inc = count_q + htwd_pkg::CNT_W'(1);

  // Step unit: judge the examined entry against the current code bit.
  always_comb begin
    stop       = 1'b0;
    emit       = 1'b0;
    advance    = 1'b0;
    go_child   = 1'b0;
    set_walk   = 1'b0;
    child_addr = cur_bit ? cur_node.right : cur_node.left;
    case (mode_q)
      htwd_pkg::MODE_ROOT, htwd_pkg::MODE_CUR: begin
        if (limit_hit) begin
          stop = 1'b1;
        end else if (cur_node.leaf) begin
          emit    = 1'b1;
          advance = 1'b1;
        end else begin
          go_child = 1'b1;
        end
      end
      htwd_pkg::MODE_CHILD: begin
        advance = 1'b1;
        if (cur_node.leaf) begin
          emit = 1'b1;
        end else begin
          // Internal child: settle here and start on the next bit at once.
          set_walk   = 1'b1;
          go_child   = !last_bit;
          child_addr = next_bit ? cur_node.right : cur_node.left;
        end
      end
      default: begin
        stop = 1'b1;
      end
    endcase
  end

  // Hold a step that emits a symbol while the previous symbol cannot move to the output register.
  assign stall = (state_q == htwd_pkg::ST_STEP) && emit && pend_valid_q && !res_room;

  always_comb begin
    state_next = state_q;
    case (state_q)
      htwd_pkg::ST_IDLE: begin
        if (in_fire && cmd == htwd_pkg::CMD_DATA) begin
          state_next = htwd_pkg::ST_STEP;
        end
      end
      htwd_pkg::ST_STEP: begin
        if (!stall && (stop || (advance && last_bit))) begin
          state_next = htwd_pkg::ST_FLUSH;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (!pend_valid_q || res_room) begin
          state_next = htwd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = htwd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    res_push          = 1'b0;
    rd_addr           = walk_q;
    node_wr.en        = 1'b0;
    node_wr.addr      = node_index;
    node_wr.node.left = left_child;
    node_wr.node.right = right_child;
    node_wr.node.leaf = leaf_flag;
    node_wr.node.sym  = leaf_symbol;
    res.symbol        = pend_q.symbol;
    res.done          = pend_q.done;
    res.last          = 1'b0;
    case (state_q)
      htwd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        node_wr.en = in_valid && cmd == htwd_pkg::CMD_LOAD;
      end
      htwd_pkg::ST_STEP: begin
        res_push = emit && pend_valid_q && res_room;
        if (stall) begin
          rd_addr = rd_addr_q;
        end else if (go_child) begin
          rd_addr = child_addr;
        end else begin
          rd_addr = rd_addr_q;
        end
      end
      htwd_pkg::ST_FLUSH: begin
        res_push = pend_valid_q && res_room;
        res.last = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    mode_next       = mode_q;
    bit_idx_next    = bit_idx_q;
    byte_next       = byte_q;
    walk_next       = walk_q;
    count_next      = count_q;
    root_next       = root_q;
    pend_valid_next = pend_valid_q;
    pend_next       = pend_q;
    case (state_q)
      htwd_pkg::ST_IDLE: begin
        if (in_fire && cmd == htwd_pkg::CMD_LOAD) begin
          walk_next  = '0;
          count_next = '0;
          if (node_index == '0) begin
            root_next = node_wr.node;
          end
        end else if (in_fire) begin
          byte_next    = coded_byte;
          bit_idx_next = htwd_pkg::BIT_IDX_W'(htwd_pkg::BYTE_W - 1);
          mode_next    = (walk_q == '0) ? htwd_pkg::MODE_ROOT : htwd_pkg::MODE_CUR;
        end
      end
      htwd_pkg::ST_STEP: begin
        if (!stall && !stop) begin
          if (emit) begin
            walk_next       = '0;
            count_next      = count_inc;
            mode_next       = htwd_pkg::MODE_ROOT;
            pend_valid_next = 1'b1;
            pend_next.symbol = cur_node.sym;
            pend_next.last  = 1'b0;
            pend_next.done  = count_inc >= symbol_limit;
          end
          if (set_walk) begin
            walk_next = rd_addr_q;
          end
          if (go_child) begin
            mode_next = htwd_pkg::MODE_CHILD;
          end
          if (advance && !last_bit) begin
            bit_idx_next = htwd_pkg::BIT_IDX_W'(bit_idx_q - 1'b1);
          end
        end
      end
      htwd_pkg::ST_FLUSH: begin
        if (res_room) begin
          pend_valid_next = 1'b0;
        end
      end
      default: begin
        pend_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= htwd_pkg::ST_IDLE;
      mode_q       <= htwd_pkg::MODE_ROOT;
      walk_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_next;
      mode_q       <= mode_next;
      walk_q       <= walk_next;
      count_q      <= count_next;
      pend_valid_q <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_idx_q <= bit_idx_next;
    byte_q    <= byte_next;
    rd_addr_q <= rd_addr;
    root_q    <= root_next;
    pend_q    <= pend_next;
  end

  `HTWD_ASSERT_IMP(a_emit_below_limit, clk, rst, (state_q == htwd_pkg::ST_STEP) && emit && !stall, count_q < symbol_limit, "symbol emitted at or past the limit")
  `HTWD_ASSERT_IMP(a_idle_nothing_held, clk, rst, state_q == htwd_pkg::ST_IDLE, !pend_valid_q, "idle with an undelivered symbol")
  `HTWD_ASSERT_IMP(a_root_mode_at_root, clk, rst, (state_q == htwd_pkg::ST_STEP) && (mode_q == htwd_pkg::MODE_ROOT), walk_q == '0, "root mode away from the root")
  `HTWD_ASSERT_NXT(a_stall_holds, clk, rst, stall, $stable(pend_q) && $stable(bit_idx_q) && $stable(walk_q) && $stable(count_q), "stalled step lost its state")
  `HTWD_ASSERT_NXT(a_load_restarts, clk, rst, in_fire && cmd == htwd_pkg::CMD_LOAD, (walk_q == '0) && (count_q == '0), "node load did not restart the walk")

endmodule

@@ rtl/htwd_out_stage.sv @@
// Output register for decoded symbols.
module htwd_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  htwd_pkg::result_t             res,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htwd_pkg::SYM_W-1:0]    symbol,
  output logic                          last_of_byte,
  output logic                          done_res
);

  htwd_pkg::result_t held;

  assign room         = !out_valid || out_ready;
  assign symbol       = held.symbol;
  assign last_of_byte = held.last;
  assign done_res     = held.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule

@@ rtl/huffman_tree_walk_decoder.sv @@
// A node load writes one table entry while idle. A data byte blocks further input until it
// is done, with one table read per cycle unless an output stall holds the walk: a step for
// each code bit and an extra step at the start of each code from an internal root or of a
// code resumed from the previous byte, plus accept and final flush; a byte that meets the
// symbol limit ends early. Output stalls hold the walk while a finished symbol waits.
// Reset clears walk position, symbol count, limit and handshake state; table is not cleared.
module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [htwd_pkg::IDX_W-1:0]    node_index,
  input  logic [htwd_pkg::IDX_W-1:0]    left_child,
  input  logic [htwd_pkg::IDX_W-1:0]    right_child,
  input  logic                          leaf_flag,
  input  logic [htwd_pkg::SYM_W-1:0]    leaf_symbol,
  input  logic [htwd_pkg::BYTE_W-1:0]   coded_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htwd_pkg::SYM_W-1:0]    symbol,
  output logic                          last_of_byte,
  output logic                          done_res,
  input  logic                          cfg_we,
  input  logic [htwd_pkg::CNT_W-1:0]    cfg_wdata
);

  logic [htwd_pkg::CNT_W-1:0]  symbol_limit;
  htwd_pkg::node_wr_t          node_wr;
  logic [htwd_pkg::IDX_W-1:0]  rd_addr;
  htwd_pkg::node_t             rd_node;
  logic                        res_push;
  htwd_pkg::result_t           res;
  logic                        res_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_limit <= '0;
    end else if (cfg_we) begin
      symbol_limit <= cfg_wdata;
    end
  end

  htwd_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_node_mem (
    .clk     (clk),
    .wr      (node_wr),
    .rd_addr (rd_addr),
    .rd_node (rd_node)
  );

  htwd_walk_seq u_walk_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .node_index   (node_index),
    .left_child   (left_child),
    .right_child  (right_child),
    .leaf_flag    (leaf_flag),
    .leaf_symbol  (leaf_symbol),
    .coded_byte   (coded_byte),
    .symbol_limit (symbol_limit),
    .node_wr      (node_wr),
    .rd_addr      (rd_addr),
    .rd_node      (rd_node),
    .res_push     (res_push),
    .res          (res),
    .res_room     (res_room)
  );

  htwd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .push         (res_push),
    .res          (res),
    .room         (res_room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol),
    .last_of_byte (last_of_byte),
    .done_res     (done_res)
  );

endmodule
